### rtl/fsot_pkg.sv
// Package for the first-free slot owner table: sizes, operation and status codes,
// register indexes and the command/status structs between controller and datapath.
// Depends on nothing; fsot_if, fsot_ctrl, fsot_dp and the top level all use it.
package fsot_pkg;

    localparam int SLOTS      = 64;
    localparam int OWNER_BITS = 16;
    localparam int FIELD_W    = 7;                 // slot numbers, counts, capacity
    localparam int IDX_W      = $clog2(SLOTS);     // index into the owner store
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REG_CAPACITY = 1'b0;          // register index, paddr[2]
    localparam logic [FIELD_W-1:0] CAP_RESET = FIELD_W'(64);

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD      = 2'd1,
        STS_FULL     = 2'd2,
        STS_WAS_FREE = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;      // latch the request and start the store read
        logic finish;      // apply the operation and load the result register
        logic cfg_clear;   // capacity written: empty the table
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;    // result register empty or being drained this cycle
    } t_dp_sts;

endpackage

### rtl/fsot_if.sv
// Request and result channel interfaces of the slot owner table.
// Depends on fsot_pkg for field widths.
interface fsot_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      op;
    logic [fsot_pkg::OWNER_BITS-1:0] owner_id;
    logic [fsot_pkg::FIELD_W-1:0]    slot_number;

    modport source (output valid, output op, output owner_id, output slot_number,
                    input ready);
    modport sink   (input valid, input op, input owner_id, input slot_number,
                    output ready);
endinterface

interface fsot_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [fsot_pkg::FIELD_W-1:0]    slot_given;
    logic [fsot_pkg::OWNER_BITS-1:0] owner_out;
    logic [fsot_pkg::FIELD_W-1:0]    free_count;
    logic [fsot_pkg::FIELD_W-1:0]    used_count;

    modport source (output valid, output status, output slot_given, output owner_out,
                    output free_count, output used_count, input ready);
    modport sink   (input valid, input status, input slot_given, input owner_out,
                    input free_count, input used_count, output ready);
endinterface

### rtl/fsot_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the owner store.
module fsot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/fsot_ctrl.sv
// Controller of the slot owner table: a two-state sequencer that takes a request,
// then applies it once the result register can take the answer. Depends on fsot_pkg.
module fsot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fsot_pkg::t_dp_sts i_sts,
    output fsot_pkg::t_dp_cmd o_cmd
);
    import fsot_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   finish;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Store read data is ready here; wait only for room in the result register.
                if (i_sts.out_free) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept    = accept;
    assign o_cmd.finish    = finish;
    assign o_cmd.cfg_clear = 1'b0;
endmodule

### rtl/fsot_dp.sv
// Datapath of the slot owner table: request registers, occupancy map, counters,
// first-free search, owner store and result register. Depends on fsot_pkg, fsot_ram.
module fsot_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fsot_pkg::t_dp_cmd               i_cmd,
    output fsot_pkg::t_dp_sts               o_sts,
    input  logic [fsot_pkg::FIELD_W-1:0]    i_eff_cap,
    input  logic [1:0]                      i_op,
    input  logic [fsot_pkg::OWNER_BITS-1:0] i_owner_id,
    input  logic [fsot_pkg::FIELD_W-1:0]    i_slot_number,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [1:0]                      o_status,
    output logic [fsot_pkg::FIELD_W-1:0]    o_slot_given,
    output logic [fsot_pkg::OWNER_BITS-1:0] o_owner_out,
    output logic [fsot_pkg::FIELD_W-1:0]    o_free_count,
    output logic [fsot_pkg::FIELD_W-1:0]    o_used_count
);
    import fsot_pkg::*;

    t_op                   r_op;
    logic [OWNER_BITS-1:0] r_owner;
    logic [FIELD_W-1:0]    r_slot;
    logic [SLOTS-1:0]      r_map;
    logic [SLOTS-1:0]      n_map;
    logic [FIELD_W-1:0]    r_free;
    logic [FIELD_W-1:0]    n_free;
    logic [FIELD_W-1:0]    r_used;
    logic [FIELD_W-1:0]    n_used;
    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [FIELD_W-1:0]    r_given;
    logic [FIELD_W-1:0]    n_given;
    logic [OWNER_BITS-1:0] r_owner_out;
    logic [OWNER_BITS-1:0] n_owner_out;

    logic [SLOTS-1:0]      cap_mask;
    logic [SLOTS-1:0]      free_vec;
    logic [SLOTS-1:0]      lowest;
    logic [IDX_W-1:0]      free_idx;
    logic                  any_free;
    logic [IDX_W-1:0]      req_idx;
    logic                  slot_ok;
    logic                  owned;
    logic [OWNER_BITS-1:0] rd_data;
    logic [FIELD_W-1:0]    in_slot_m1;
    logic                  ram_we;

    // Slots 1..capacity are usable; the lowest free one is isolated with x & -x.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            cap_mask[i] = (FIELD_W'(i) < i_eff_cap);
        end
        free_vec = ~r_map & cap_mask;
        lowest   = free_vec & (~free_vec + SLOTS'(1));
        any_free = |free_vec;
        free_idx = '0;
        for (int b = 0; b < IDX_W; b++) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    free_idx[b] = free_idx[b] | lowest[i];
                end
            end
        end
    end

    assign in_slot_m1 = i_slot_number - FIELD_W'(1);
    assign req_idx    = IDX_W'(r_slot - FIELD_W'(1));
    assign slot_ok    = (r_slot != '0) && (r_slot <= i_eff_cap);
    assign owned      = r_map[req_idx];
    assign ram_we     = i_cmd.finish && (r_op == OP_RESERVE) && (r_owner != '0) && any_free;

    fsot_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_idx),
        .i_wdata (r_owner),
        .i_re    (i_cmd.accept),
        .i_raddr (IDX_W'(in_slot_m1)),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_map       = r_map;
        n_free      = r_free;
        n_used      = r_used;
        n_status    = STS_OK;
        n_given     = '0;
        n_owner_out = '0;
        case (r_op)
            OP_RESERVE: begin
                if (r_owner == '0) begin
                    n_status = STS_BAD;
                end else if (!any_free) begin
                    n_status = STS_FULL;
                end else begin
                    n_map    = r_map | lowest;
                    n_used   = r_used + FIELD_W'(1);
                    n_free   = r_free - FIELD_W'(1);
                    n_given  = FIELD_W'(free_idx) + FIELD_W'(1);
                end
            end
            OP_CLEAR: begin
                n_map  = '0;
                n_free = i_eff_cap;
                n_used = '0;
            end
            default: begin
                if (!slot_ok) begin
                    n_status = STS_BAD;
                end else if (r_op == OP_RELEASE) begin
                    if (owned) begin
                        n_owner_out      = rd_data;
                        n_map[req_idx]   = 1'b0;
                        n_used           = r_used - FIELD_W'(1);
                        n_free           = r_free + FIELD_W'(1);
                    end else begin
                        n_status = STS_WAS_FREE;
                    end
                end else if (owned) begin
                    n_owner_out = rd_data;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_op);
            r_owner <= i_owner_id;
            r_slot  <= i_slot_number;
        end
        if (i_cmd.finish) begin
            r_status    <= n_status;
            r_given     <= n_given;
            r_owner_out <= n_owner_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_free      <= CAP_RESET;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_clear) begin
                r_map  <= '0;
                r_free <= i_eff_cap;
                r_used <= '0;
            end else if (i_cmd.finish) begin
                r_map  <= n_map;
                r_free <= n_free;
                r_used <= n_used;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Counts are taken after the operation, so they are latched with the result.
    logic [FIELD_W-1:0] r_free_out;
    logic [FIELD_W-1:0] r_used_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_free_out <= n_free;
            r_used_out <= n_used;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot_given   = r_given;
    assign o_owner_out    = r_owner_out;
    assign o_free_count   = r_free_out;
    assign o_used_count   = r_used_out;
endmodule

### rtl/first_free_slot_owner_table_top.sv
// First-free slot owner table, top level. Depends on fsot_pkg, fsot_if, fsot_ctrl, fsot_dp.
// A request is registered on acceptance, together with the read of the owner store; the
// result is registered once the result register has room, and a new request is taken only
// after the previous one has been applied, as the controller waits in its execute state.
// Reset (synchronous, active low) empties the table, sets capacity to 64 and clears the
// result valid flag; no clearing pass is needed, the occupancy map gates store read data.
module first_free_slot_owner_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fsot_req_if.sink                      i_req,
    fsot_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsot_pkg::APB_AW-1:0]   paddr,
    input  logic [fsot_pkg::APB_DW-1:0]   pwdata,
    output logic [fsot_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import fsot_pkg::*;

    // Capacity register. Its stored value is read back as written; the value the
    // table actually uses saturates at the number of physical slots.
    logic [FIELD_W-1:0] r_capacity;
    logic [FIELD_W-1:0] eff_cap;
    logic               cfg_write;
    t_dp_cmd            ctrl_cmd;
    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;

    // Writes complete in the access phase; pready is tied high so no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[FIELD_W-1:0];
        end
    end

    assign eff_cap = (r_capacity > FIELD_W'(SLOTS)) ? FIELD_W'(SLOTS) : r_capacity;

    // A capacity write also empties the table; the datapath sees it as one more command.
    // The new capacity is already in place when the clear is applied in the following cycle;
    // the user must write configuration only while the block is idle; it does not enforce this.
    logic r_cfg_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_clear <= 1'b0;
        end else begin
            r_cfg_clear <= cfg_write;
        end
    end

    always_comb begin
        dp_cmd           = ctrl_cmd;
        dp_cmd.cfg_clear = r_cfg_clear;
    end

    fsot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    fsot_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_eff_cap     (eff_cap),
        .i_op          (i_req.op),
        .i_owner_id    (i_req.owner_id),
        .i_slot_number (i_req.slot_number),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_slot_given  (o_rsp.slot_given),
        .o_owner_out   (o_rsp.owner_out),
        .o_free_count  (o_rsp.free_count),
        .o_used_count  (o_rsp.used_count)
    );
endmodule
